### sv/fcca_pkg.sv
// Package for the FAT12 cluster chain allocator.
// Field widths, command and state codes, table port request type.
// No dependencies; compiled first.
package fcca_pkg;

  localparam int ENTRY_W  = 12;
  localparam int CMD_W    = 2;
  localparam int SECTOR_W = 13;
  localparam int BYTES_W  = 22;
  localparam int TS_W     = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_ALLOC = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_RESOLVE,
    ST_DONE
  } state_t;

  localparam logic [ENTRY_W-1:0] END_MARK         = 12'hFFF;
  localparam logic [TS_W-1:0]    RESERVED_SECTORS = 16'd32;
  localparam logic [TS_W-1:0]    MIN_SECTORS      = 16'd34;
  localparam logic [TS_W-1:0]    TS_RESET         = 16'd2880;
  localparam int                 FIRST_CLUSTER    = 2;
  localparam logic [BYTES_W-1:0] FREE_BYTES_MAX   = '1;

  // one write port and one read port per cycle into the table
  typedef struct packed {
    logic               we;
    logic [ENTRY_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] raddr;
  } tbl_req_t;

endpackage

### sv/fcca_in_if.sv
// Command channel of the allocator: valid/ready plus one command transaction.
// Depends on fcca_pkg for field widths.
interface fcca_in_if;
  logic                         valid;
  logic                         ready;
  logic [fcca_pkg::CMD_W-1:0]   command;
  logic [fcca_pkg::ENTRY_W-1:0] entry_index;
  logic [fcca_pkg::ENTRY_W-1:0] entry_value;
  logic                         last_cluster;

  modport source (output valid, command, entry_index, entry_value, last_cluster,
                  input ready);
  modport sink   (input valid, command, entry_index, entry_value, last_cluster,
                  output ready);
endinterface

### sv/fcca_out_if.sv
// Result channel of the allocator: valid/ready plus one result transaction.
// Depends on fcca_pkg for field widths.
interface fcca_out_if;
  logic                          valid;
  logic                          ready;
  logic [fcca_pkg::ENTRY_W-1:0]  cluster;
  logic [fcca_pkg::SECTOR_W-1:0] sector_number;
  logic [fcca_pkg::ENTRY_W-1:0]  read_value;
  logic [fcca_pkg::BYTES_W-1:0]  free_bytes;
  logic                          status;

  modport source (output valid, cluster, sector_number, read_value, free_bytes, status,
                  input ready);
  modport sink   (input valid, cluster, sector_number, read_value, free_bytes, status,
                  output ready);
endinterface

### sv/fcca_cfg_if.sv
// Configuration write channel: total_sectors register, valid/ready.
// Depends on fcca_pkg for the data width.
interface fcca_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fcca_pkg::TS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/fcca_table.sv
// FAT entry store: one write and one registered read per cycle.
// Depends on fcca_pkg (tbl_req_t). Contents undefined until loaded.
module fcca_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  fcca_pkg::tbl_req_t              req,
  output logic [fcca_pkg::ENTRY_W-1:0]    rdata
);
  import fcca_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

### sv/fat12_cluster_chain_allocator.sv
// FAT12 cluster chain allocator: table load/read, free count, chain allocation.
// Load goes to resolve and done; read first passes a table read state; count and allocate
// sweep clusters 2 up to the last usable one, reading one table entry a cycle on one port.
// One command in flight; a finished result may wait while the next is accepted.
// Reset (synchronous) closes any open chain and restores total_sectors to 2880;
// table contents are undefined until loaded, no clearing pass.
module fat12_cluster_chain_allocator #(
  parameter int FAT_ENTRIES        = 4096,
  parameter int DATA_SECTOR_OFFSET = 31,
  parameter int SECTOR_BYTES       = 512
) (
  input logic        clk,
  input logic        rst,
  fcca_in_if.sink    in_ch,
  fcca_out_if.source out_ch,
  fcca_cfg_if.sink   cfg
);
  import fcca_pkg::*;

  localparam int AW = $clog2(FAT_ENTRIES);
  localparam int CW = AW + 1;

  state_t state, state_next;

  cmd_t               cmd;
  logic [ENTRY_W-1:0] idx;
  logic [ENTRY_W-1:0] val;
  logic               last;
  logic               chain_open;
  logic [ENTRY_W-1:0] cur;
  logic [TS_W-1:0]    ts;

  logic [CW-1:0]      scan_addr;
  logic               rvalid;
  logic [AW-1:0]      ridx;
  logic [ENTRY_W-1:0] skip;
  logic [AW-1:0]      cnt;
  logic [ENTRY_W-1:0] hit1;
  logic [ENTRY_W-1:0] hit2;

  logic [ENTRY_W-1:0]  res_cluster;
  logic [SECTOR_W-1:0] res_sector;
  logic [ENTRY_W-1:0]  res_read;
  logic [BYTES_W-1:0]  res_bytes;
  logic                res_status;

  tbl_req_t           req;
  logic [ENTRY_W-1:0] rdata;

  logic               in_acc;
  logic               has_usable;
  logic [TS_W-1:0]    ts_minus;
  logic [AW-1:0]      top;
  logic               iss;
  logic               hit;
  logic               enough;
  logic               scan_end;
  logic               idx_ok;
  logic [ENTRY_W-1:0] m;
  logic               have;
  logic [ENTRY_W-1:0] nx;
  logic               nx_ok;
  logic [31:0]        prod;
  logic               out_load;

  fcca_table #(.DEPTH(FAT_ENTRIES), .AW(AW)) u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign cfg.ready = 1'b1;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_load  = (state == ST_DONE) && (!out_ch.valid || out_ch.ready);

  // usable clusters are 2 .. min(total_sectors - 32, entries - 1)
  assign has_usable = ts >= MIN_SECTORS;
  always_comb begin
    ts_minus = ts - RESERVED_SECTORS;
    if (ts_minus > TS_W'(FAT_ENTRIES - 1)) begin
      top = AW'(FAT_ENTRIES - 1);
    end else begin
      top = ts_minus[AW-1:0];
    end
  end

  // allocation stops as soon as it has the clusters it needs
  assign enough = (cmd == CMD_ALLOC) &&
                  ((!chain_open && !last) ? (cnt >= AW'(2)) : (cnt >= AW'(1)));
  assign iss      = (state == ST_SCAN) && !enough && (scan_addr <= CW'(top));
  assign hit      = (state == ST_SCAN) && rvalid && (rdata == '0) &&
                    (ENTRY_W'(ridx) != skip);
  assign scan_end = (state == ST_SCAN) && (enough || (!iss && !rvalid));

  assign idx_ok = 32'(idx) < FAT_ENTRIES;
  assign m      = chain_open ? cur : hit1;
  assign have   = chain_open || (cnt != '0);
  assign nx     = chain_open ? hit1 : hit2;
  assign nx_ok  = chain_open ? (cnt >= AW'(1)) : (cnt >= AW'(2));
  assign prod   = 32'(cnt) * 32'(SECTOR_BYTES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_t'(in_ch.command))
            CMD_LOAD:  state_next = ST_RESOLVE;
            CMD_READ:  state_next = ST_READ;
            CMD_COUNT: state_next = has_usable ? ST_SCAN : ST_RESOLVE;
            CMD_ALLOC: state_next = (has_usable && !(chain_open && in_ch.last_cluster)) ?
                                    ST_SCAN : ST_RESOLVE;
            default:   state_next = ST_RESOLVE;
          endcase
        end
      end
      ST_READ:    state_next = ST_RESOLVE;
      ST_SCAN:    state_next = scan_end ? ST_RESOLVE : ST_SCAN;
      ST_RESOLVE: state_next = ST_DONE;
      ST_DONE:    state_next = out_load ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs: handshake and table port
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    req.we      = 1'b0;
    req.waddr   = idx;
    req.wdata   = val;
    req.raddr   = (state == ST_READ) ? idx : ENTRY_W'(scan_addr);
    if (state == ST_RESOLVE) begin
      case (cmd)
        CMD_LOAD: begin
          req.we = idx_ok;
        end
        CMD_ALLOC: begin
          req.we    = have;
          req.waddr = m;
          req.wdata = (last || !nx_ok) ? END_MARK : nx;
        end
        default: begin
          req.we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      chain_open <= 1'b0;
      cur        <= '0;
      ts         <= TS_RESET;
      rvalid     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= iss;
      if (cfg.valid && cfg.ready) begin
        ts <= cfg.data;
      end
      if (state == ST_RESOLVE && cmd == CMD_ALLOC && have) begin
        if (last || !nx_ok) begin
          chain_open <= 1'b0;
          cur        <= '0;
        end else begin
          chain_open <= 1'b1;
          cur        <= nx;
        end
      end
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // command capture and sweep datapath
  always_ff @(posedge clk) begin
    ridx <= scan_addr[AW-1:0];
    if (in_acc) begin
      cmd       <= cmd_t'(in_ch.command);
      idx       <= in_ch.entry_index;
      val       <= in_ch.entry_value;
      last      <= in_ch.last_cluster;
      // count has no cluster to skip; 0 never lies in the swept range
      skip      <= (cmd_t'(in_ch.command) == CMD_ALLOC && chain_open) ? cur : '0;
      cnt       <= '0;
      scan_addr <= CW'(FIRST_CLUSTER);
    end else begin
      if (iss) begin
        scan_addr <= scan_addr + CW'(1);
      end
      if (hit && !enough) begin
        cnt <= cnt + AW'(1);
        if (cnt == '0) begin
          hit1 <= ENTRY_W'(ridx);
        end else if (cnt == AW'(1)) begin
          hit2 <= ENTRY_W'(ridx);
        end
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (state == ST_RESOLVE) begin
      res_cluster <= '0;
      res_sector  <= '0;
      res_read    <= '0;
      res_bytes   <= '0;
      res_status  <= 1'b0;
      case (cmd)
        CMD_READ: begin
          res_read <= idx_ok ? rdata : '0;
        end
        CMD_COUNT: begin
          res_bytes <= (prod > 32'(FREE_BYTES_MAX)) ? FREE_BYTES_MAX : prod[BYTES_W-1:0];
        end
        CMD_ALLOC: begin
          if (!have) begin
            res_status <= 1'b1;
          end else begin
            res_cluster <= m;
            res_sector  <= SECTOR_W'(DATA_SECTOR_OFFSET) + SECTOR_W'(m);
            res_status  <= !last && !nx_ok;
          end
        end
        default: begin
          res_status <= 1'b0;
        end
      endcase
    end
    if (out_load) begin
      out_ch.cluster       <= res_cluster;
      out_ch.sector_number <= res_sector;
      out_ch.read_value    <= res_read;
      out_ch.free_bytes    <= res_bytes;
      out_ch.status        <= res_status;
    end
  end

endmodule

### sv/fcca_checker.sv
// Port-level checks for the allocator, attached to the top level by bind.
// Depends on fcca_pkg and fat12_cluster_chain_allocator.
module fcca_checker #(
  parameter int DATA_SECTOR_OFFSET = 31
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fcca_pkg::ENTRY_W-1:0]  cluster,
  input logic [fcca_pkg::SECTOR_W-1:0] sector_number,
  input logic [fcca_pkg::ENTRY_W-1:0]  read_value,
  input logic [fcca_pkg::BYTES_W-1:0]  free_bytes,
  input logic                          status
);
  import fcca_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one command in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in flight");

  a_sector_tracks_cluster: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_number != '0 |->
      sector_number == SECTOR_W'(DATA_SECTOR_OFFSET) + SECTOR_W'(cluster))
    else $error("sector number does not follow cluster");

  a_count_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && free_bytes != '0 |-> cluster == '0 && read_value == '0 && !status)
    else $error("count transaction carries other fields");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cluster) && $stable(sector_number) &&
      $stable(read_value) && $stable(free_bytes) && $stable(status))
    else $error("stalled result changed");

endmodule

bind fat12_cluster_chain_allocator fcca_checker #(
  .DATA_SECTOR_OFFSET(DATA_SECTOR_OFFSET)
) u_fcca_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .cluster       (out_ch.cluster),
  .sector_number (out_ch.sector_number),
  .read_value    (out_ch.read_value),
  .free_bytes    (out_ch.free_bytes),
  .status        (out_ch.status)
);
